/* src/cslr_pkg.sv */
package cslr_pkg;

  // Item kinds
  localparam logic [2:0] MODE_BUS_READ  = 3'd0;
  localparam logic [2:0] MODE_BUS_WRITE = 3'd1;
  localparam logic [2:0] MODE_LINE_IN   = 3'd2;
  localparam logic [2:0] MODE_TX_TAKE   = 3'd3;
  localparam logic [2:0] MODE_TICK      = 3'd4;

  // Register word select
  localparam logic [1:0] REG_RX_CSR = 2'd0;
  localparam logic [1:0] REG_RX_BUF = 2'd1;
  localparam logic [1:0] REG_TX_CSR = 2'd2;
  localparam logic [1:0] REG_TX_BUF = 2'd3;

  // Status bit positions and character mask
  localparam int unsigned BIT_DONE_READY = 7;
  localparam int unsigned BIT_ENABLE     = 6;
  localparam logic [6:0]  CHAR_MASK      = 7'h7F;

  typedef struct packed {
    logic [2:0]  mode;
    logic [1:0]  reg_select;
    logic [15:0] write_data;
    logic [7:0]  line_byte;
  } item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [6:0]  out_byte;
    logic        out_valid;
    logic        tx_pending;
  } result_t;

endpackage

/* src/cslr_ram.sv */
module cslr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/console_serial_line_registers_top.sv */
// Channel  | Ports                | Beat taken when
// ---------+----------------------+---------------------------------
// item in  | start, busy, item    | start high and busy low
// result   | strobe, result       | strobe high (one cycle, no stall)
//
// One item per cycle; busy stays low after reset.
// Each result appears in the cycle after its item is taken (registered queue read).
// The queues are RAMs of QUEUE_DEPTH entries with no clearing pass; only the
// pointers, flags and held byte are reset (synchronous rst).
// The result side cannot stall, so nothing is held back.
module console_serial_line_registers_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  cslr_pkg::item_t  item,
  output logic             strobe,
  output cslr_pkg::result_t result
);

  import cslr_pkg::*;

  localparam int SLOT_W = $clog2(QUEUE_DEPTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_DEPTH - 1);

  // Queue pointers: slot plus wrap phase
  logic [SLOT_W-1:0] rx_wr_slot, rx_rd_slot, tx_wr_slot, tx_rd_slot;
  logic              rx_wr_phase, rx_rd_phase, tx_wr_phase, tx_rd_phase;
  logic [SLOT_W-1:0] tx_wr_slot_next, tx_rd_slot_next;
  logic              tx_wr_phase_next, tx_rd_phase_next;

  logic       rx_done, rx_int_enable, tx_int_enable, tx_ready;
  logic [7:0] held_rx_byte;
  logic       held_load;

  logic        accept;
  logic        rx_empty, rx_full, tx_empty, tx_full;
  logic        rx_push, rx_pop, tx_push, tx_pop;
  logic [7:0]  held_now;
  logic [15:0] read_data_next;
  logic [7:0]  rx_rdata;
  logic [6:0]  tx_rdata;
  logic [15:0] read_data;
  logic        take_ok, tx_pending;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign rx_empty = (rx_wr_slot == rx_rd_slot) && (rx_wr_phase == rx_rd_phase);
  assign rx_full  = (rx_wr_slot == rx_rd_slot) && (rx_wr_phase != rx_rd_phase);
  assign tx_empty = (tx_wr_slot == tx_rd_slot) && (tx_wr_phase == tx_rd_phase);
  assign tx_full  = (tx_wr_slot == tx_rd_slot) && (tx_wr_phase != tx_rd_phase);

  // Queue operations for this beat
  assign rx_push = accept && (item.mode == MODE_LINE_IN) && !rx_full;
  assign rx_pop  = accept && (item.mode == MODE_TICK) && !rx_empty && !rx_done;
  assign tx_push = accept && (item.mode == MODE_BUS_WRITE) &&
                   (item.reg_select == REG_TX_BUF) && !tx_full;
  assign tx_pop  = accept && (item.mode == MODE_TX_TAKE) && !tx_empty;

  // Held byte as seen now: last tick's queue read comes from the registered RAM output
  assign held_now = held_load ? rx_rdata : held_rx_byte;

  // Transmit pointers after this beat (drive tx_pending)
  always_comb begin
    tx_wr_slot_next  = tx_wr_slot;
    tx_wr_phase_next = tx_wr_phase;
    tx_rd_slot_next  = tx_rd_slot;
    tx_rd_phase_next = tx_rd_phase;
    if (tx_push) begin
      tx_wr_slot_next  = (tx_wr_slot == LAST_SLOT) ? '0 : tx_wr_slot + 1'b1;
      tx_wr_phase_next = (tx_wr_slot == LAST_SLOT) ? !tx_wr_phase : tx_wr_phase;
    end
    if (tx_pop) begin
      tx_rd_slot_next  = (tx_rd_slot == LAST_SLOT) ? '0 : tx_rd_slot + 1'b1;
      tx_rd_phase_next = (tx_rd_slot == LAST_SLOT) ? !tx_rd_phase : tx_rd_phase;
    end
  end

  // Bus read mux
  always_comb begin
    read_data_next = '0;
    if (item.mode == MODE_BUS_READ) begin
      case (item.reg_select)
        REG_RX_CSR: begin
          read_data_next[BIT_DONE_READY] = rx_done;
          read_data_next[BIT_ENABLE]     = rx_int_enable;
        end
        REG_RX_BUF: read_data_next = {8'd0, held_now};
        REG_TX_CSR: begin
          read_data_next[BIT_DONE_READY] = tx_ready;
          read_data_next[BIT_ENABLE]     = tx_int_enable;
        end
        default: read_data_next = '0;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_wr_slot    <= '0;
      rx_wr_phase   <= 1'b0;
      rx_rd_slot    <= '0;
      rx_rd_phase   <= 1'b0;
      tx_wr_slot    <= '0;
      tx_wr_phase   <= 1'b0;
      tx_rd_slot    <= '0;
      tx_rd_phase   <= 1'b0;
      held_rx_byte  <= '0;
      held_load     <= 1'b0;
      rx_done       <= 1'b0;
      rx_int_enable <= 1'b0;
      tx_int_enable <= 1'b0;
      tx_ready      <= 1'b1;
      strobe        <= 1'b0;
      take_ok       <= 1'b0;
      tx_pending    <= 1'b0;
    end else begin
      tx_wr_slot  <= tx_wr_slot_next;
      tx_wr_phase <= tx_wr_phase_next;
      tx_rd_slot  <= tx_rd_slot_next;
      tx_rd_phase <= tx_rd_phase_next;
      if (rx_push) begin
        rx_wr_slot  <= (rx_wr_slot == LAST_SLOT) ? '0 : rx_wr_slot + 1'b1;
        rx_wr_phase <= (rx_wr_slot == LAST_SLOT) ? !rx_wr_phase : rx_wr_phase;
      end
      if (rx_pop) begin
        rx_rd_slot  <= (rx_rd_slot == LAST_SLOT) ? '0 : rx_rd_slot + 1'b1;
        rx_rd_phase <= (rx_rd_slot == LAST_SLOT) ? !rx_rd_phase : rx_rd_phase;
      end
      held_load <= rx_pop;
      if (held_load) begin
        held_rx_byte <= rx_rdata;
      end
      if (accept) begin
        case (item.mode)
          MODE_BUS_READ: begin
            if (item.reg_select == REG_RX_BUF) begin
              rx_done <= 1'b0;
            end
          end
          MODE_BUS_WRITE: begin
            if (item.reg_select == REG_RX_CSR) begin
              rx_int_enable <= item.write_data[BIT_ENABLE];
            end else if (item.reg_select == REG_TX_CSR) begin
              tx_int_enable <= item.write_data[BIT_ENABLE];
            end
          end
          MODE_TICK: begin
            tx_ready <= 1'b1;
            if (rx_pop) begin
              rx_done <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      strobe     <= accept;
      take_ok    <= tx_pop;
      tx_pending <= !((tx_wr_slot_next == tx_rd_slot_next) &&
                      (tx_wr_phase_next == tx_rd_phase_next));
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      read_data <= read_data_next;
    end
  end

  assign result.read_data  = read_data;
  assign result.out_byte   = take_ok ? (tx_rdata & CHAR_MASK) : '0;
  assign result.out_valid  = take_ok;
  assign result.tx_pending = tx_pending;

  // Queue storage
  cslr_ram #(
    .WIDTH(8),
    .DEPTH(QUEUE_DEPTH)
  ) u_rx_ram (
    .clk  (clk),
    .we   (rx_push),
    .waddr(rx_wr_slot),
    .wdata(item.line_byte),
    .re   (rx_pop),
    .raddr(rx_rd_slot),
    .rdata(rx_rdata)
  );

  cslr_ram #(
    .WIDTH(7),
    .DEPTH(QUEUE_DEPTH)
  ) u_tx_ram (
    .clk  (clk),
    .we   (tx_push),
    .waddr(tx_wr_slot),
    .wdata(item.write_data[6:0] & CHAR_MASK),
    .re   (tx_pop),
    .raddr(tx_rd_slot),
    .rdata(tx_rdata)
  );

  // Every taken beat yields exactly one result on the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> strobe)
    else $error("result strobe missing after accepted item");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    !accept |=> !strobe)
    else $error("result strobe without accepted item");

  // A dequeue only happens from a non-empty transmit queue
  a_take_nonempty: assert property (@(posedge clk) disable iff (rst)
    tx_pop |-> !tx_empty && !tx_push)
    else $error("transmit dequeue from empty queue");

  // Occupancy never exceeds depth
  a_rx_bound: assert property (@(posedge clk) disable iff (rst)
    (rx_wr_phase != rx_rd_phase) |-> (rx_wr_slot <= rx_rd_slot))
    else $error("receive queue over depth");

  a_tx_bound: assert property (@(posedge clk) disable iff (rst)
    (tx_wr_phase != tx_rd_phase) |-> (tx_wr_slot <= tx_rd_slot))
    else $error("transmit queue over depth");

  // Held byte load always follows a tick that set done
  a_held_done: assert property (@(posedge clk) disable iff (rst)
    rx_pop |=> held_load && rx_done)
    else $error("held byte load without done");

endmodule
